>>> rtl/core/ocs_pkg.sv
package ocs_pkg;

   localparam int ModeWidth  = 4;
   localparam int ByteWidth  = 8;
   localparam int IndexWidth = 5;
   localparam int InitLen    = 25;

   localparam logic [ModeWidth-1:0] MODE_WRITE    = 4'd0;
   localparam logic [ModeWidth-1:0] MODE_CMDLVL   = 4'd1;
   localparam logic [ModeWidth-1:0] MODE_DATALVL  = 4'd2;
   localparam logic [ModeWidth-1:0] MODE_SLEEP    = 4'd3;
   localparam logic [ModeWidth-1:0] MODE_WAKE     = 4'd4;
   localparam logic [ModeWidth-1:0] MODE_INIT     = 4'd5;
   localparam logic [ModeWidth-1:0] MODE_CONTRAST = 4'd6;
   localparam logic [ModeWidth-1:0] MODE_HFLIP    = 4'd7;
   localparam logic [ModeWidth-1:0] MODE_VFLIP    = 4'd8;
   localparam logic [ModeWidth-1:0] MODE_INVERT   = 4'd9;
   localparam logic [ModeWidth-1:0] MODE_HSCROLL  = 4'd10;
   localparam logic [ModeWidth-1:0] MODE_DIAG     = 4'd11;
   localparam logic [ModeWidth-1:0] MODE_STOP     = 4'd12;
   localparam logic [ModeWidth-1:0] MODE_ADDRMODE = 4'd13;
   localparam logic [ModeWidth-1:0] MODE_COLS     = 4'd14;
   localparam logic [ModeWidth-1:0] MODE_PAGES    = 4'd15;

   localparam logic [7:0] CMD_DISPLAY_OFF   = 8'hAE;
   localparam logic [7:0] CMD_DISPLAY_ON    = 8'hAF;
   localparam logic [7:0] CMD_CONTRAST      = 8'h81;
   localparam logic [7:0] CMD_SCROLL_OFF    = 8'h2E;
   localparam logic [7:0] CMD_SCROLL_ON     = 8'h2F;
   localparam logic [7:0] CMD_VSCROLL_AREA  = 8'hA3;
   localparam logic [7:0] CMD_DIAG_RIGHT    = 8'h29;
   localparam logic [7:0] CMD_DIAG_LEFT     = 8'h2A;
   localparam logic [7:0] CMD_HSCROLL_RIGHT = 8'h26;
   localparam logic [7:0] CMD_HSCROLL_LEFT  = 8'h27;
   localparam logic [7:0] CMD_ADDR_MODE     = 8'h20;
   localparam logic [7:0] CMD_COL_ADDR      = 8'h21;
   localparam logic [7:0] CMD_PAGE_ADDR     = 8'h22;
   localparam logic [7:0] CMD_SEG_NORMAL    = 8'hA0;
   localparam logic [7:0] CMD_SEG_REMAP     = 8'hA1;
   localparam logic [7:0] CMD_COM_NORMAL    = 8'hC0;
   localparam logic [7:0] CMD_COM_REMAP     = 8'hC8;
   localparam logic [7:0] CMD_NORMAL_VIDEO  = 8'hA6;
   localparam logic [7:0] CMD_INVERT_VIDEO  = 8'hA7;
   localparam logic [7:0] CMD_VSCROLL_ROWS  = 8'h40;
   localparam logic [7:0] CMD_FILL_ZERO     = 8'h00;
   localparam logic [7:0] CMD_FILL_ONES     = 8'hFF;

   localparam logic [7:0] PAGE_MAX   = 8'd7;
   localparam logic [7:0] COLUMN_MAX = 8'd127;
   localparam logic [7:0] SPEED_MAX  = 8'd7;
   localparam logic [7:0] VOFF_MAX   = 8'd63;
   localparam logic [7:0] ADDR_MAX   = 8'd2;

   localparam logic [7:0] INIT_SEQ [InitLen] = '{
      8'hAE, 8'hD5, 8'h80, 8'hA8, 8'h3F, 8'hD3, 8'h00, 8'h40, 8'h8D, 8'h14,
      8'h20, 8'h00, 8'hA1, 8'hC8, 8'hDA, 8'h12, 8'h81, 8'h7F, 8'hD9, 8'hF1,
      8'hDB, 8'h40, 8'hA4, 8'hA6, 8'hAF
   };

   typedef struct packed {
      logic [ModeWidth-1:0] mode;
      logic [ByteWidth-1:0] value;
      logic                 direction;
      logic [ByteWidth-1:0] range_start;
      logic [ByteWidth-1:0] range_end;
      logic [ByteWidth-1:0] speed;
      logic [ByteWidth-1:0] row_offset;
      logic                 last_in;
   } req_type;

   typedef struct packed {
      logic [ByteWidth-1:0] data;
      logic                 fend;
   } seq_byte_type;

   typedef struct packed {
      logic load;
      logic emit;
   } ocs_cmd_type;

   typedef struct packed {
      logic done;
      logic out_free;
   } ocs_stat_type;

   function automatic logic pages_bad(input logic [7:0] rs, input logic [7:0] re);
      return (rs > PAGE_MAX) || (re > PAGE_MAX) || (re < rs);
   endfunction

   function automatic logic check_bad(input req_type r);
      logic bad;
      bad = 1'b0;
      case (r.mode)
         MODE_HSCROLL:  bad = pages_bad(r.range_start, r.range_end) || (r.speed > SPEED_MAX);
         MODE_DIAG:     bad = pages_bad(r.range_start, r.range_end) || (r.speed > SPEED_MAX)
                              || (r.row_offset == 8'd0) || (r.row_offset > VOFF_MAX);
         MODE_ADDRMODE: bad = r.value > ADDR_MAX;
         MODE_COLS:     bad = (r.range_start > COLUMN_MAX) || (r.range_end > COLUMN_MAX)
                              || (r.range_end < r.range_start);
         MODE_PAGES:    bad = pages_bad(r.range_start, r.range_end);
         default:       bad = 1'b0;
      endcase
      return bad;
   endfunction

   function automatic logic [IndexWidth-1:0] seq_len(input logic [ModeWidth-1:0] mode,
                                                     input logic bad);
      logic [IndexWidth-1:0] n;
      case (mode)
         MODE_CMDLVL, MODE_DATALVL:       n = 5'd0;
         MODE_INIT:                       n = IndexWidth'(InitLen);
         MODE_CONTRAST, MODE_ADDRMODE:    n = 5'd2;
         MODE_HSCROLL:                    n = 5'd9;
         MODE_DIAG:                       n = 5'd11;
         MODE_COLS, MODE_PAGES:           n = 5'd3;
         default:                         n = 5'd1;
      endcase
      if (bad) begin
         n = 5'd1;
      end
      return n;
   endfunction

   function automatic seq_byte_type seq_byte(input req_type r,
                                             input logic [IndexWidth-1:0] idx);
      seq_byte_type s;
      s.data = CMD_FILL_ZERO;
      s.fend = 1'b0;
      case (r.mode)
         MODE_SLEEP: begin
            s.data = CMD_DISPLAY_OFF;
            s.fend = 1'b1;
         end
         MODE_WAKE: begin
            s.data = CMD_DISPLAY_ON;
            s.fend = 1'b1;
         end
         MODE_INIT: begin
            if (idx < IndexWidth'(InitLen)) begin
               s.data = INIT_SEQ[idx];
            end
            s.fend = (idx == IndexWidth'(InitLen - 1));
         end
         MODE_CONTRAST: begin
            s.data = (idx == 5'd0) ? CMD_CONTRAST : r.value;
            s.fend = (idx == 5'd1);
         end
         MODE_HFLIP: begin
            s.data = (r.value != 8'd0) ? CMD_SEG_REMAP : CMD_SEG_NORMAL;
            s.fend = 1'b1;
         end
         MODE_VFLIP: begin
            s.data = (r.value != 8'd0) ? CMD_COM_REMAP : CMD_COM_NORMAL;
            s.fend = 1'b1;
         end
         MODE_INVERT: begin
            s.data = (r.value != 8'd0) ? CMD_INVERT_VIDEO : CMD_NORMAL_VIDEO;
            s.fend = 1'b1;
         end
         MODE_HSCROLL: begin
            case (idx)
               5'd0:    s.data = CMD_SCROLL_OFF;
               5'd1:    s.data = r.direction ? CMD_HSCROLL_LEFT : CMD_HSCROLL_RIGHT;
               5'd3:    s.data = r.range_start;
               5'd4:    s.data = r.speed;
               5'd5:    s.data = r.range_end;
               5'd7:    s.data = CMD_FILL_ONES;
               5'd8:    s.data = CMD_SCROLL_ON;
               default: s.data = CMD_FILL_ZERO;
            endcase
            s.fend = (idx == 5'd0) || (idx == 5'd8);
         end
         MODE_DIAG: begin
            case (idx)
               5'd0:    s.data = CMD_SCROLL_OFF;
               5'd1:    s.data = CMD_VSCROLL_AREA;
               5'd3:    s.data = CMD_VSCROLL_ROWS;
               5'd4:    s.data = r.direction ? CMD_DIAG_LEFT : CMD_DIAG_RIGHT;
               5'd6:    s.data = r.range_start;
               5'd7:    s.data = r.speed;
               5'd8:    s.data = r.range_end;
               5'd9:    s.data = r.row_offset;
               5'd10:   s.data = CMD_SCROLL_ON;
               default: s.data = CMD_FILL_ZERO;
            endcase
            s.fend = (idx == 5'd0) || (idx == 5'd3) || (idx == 5'd10);
         end
         MODE_STOP: begin
            s.data = CMD_SCROLL_OFF;
            s.fend = 1'b1;
         end
         MODE_ADDRMODE: begin
            s.data = (idx == 5'd0) ? CMD_ADDR_MODE : r.value;
            s.fend = (idx == 5'd1);
         end
         MODE_COLS, MODE_PAGES: begin
            case (idx)
               5'd0:    s.data = (r.mode == MODE_COLS) ? CMD_COL_ADDR : CMD_PAGE_ADDR;
               5'd1:    s.data = r.range_start;
               default: s.data = r.range_end;
            endcase
            s.fend = (idx == 5'd2);
         end
         default: begin
            s.data = CMD_FILL_ZERO;
            s.fend = 1'b0;
         end
      endcase
      return s;
   endfunction

endpackage

>>> rtl/core/ocs_ctrl.sv
module ocs_ctrl
   import ocs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ocs_stat_type stat,
   output ocs_cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_RUN;
         ST_RUN:  if (stat.done) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign cmd.load  = req_ready && req_valid;
   assign cmd.emit  = (state_ff == ST_RUN) && !stat.done && stat.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/ocs_datapath.sv
module ocs_datapath
   import ocs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req,
   input  ocs_cmd_type          cmd,
   output ocs_stat_type         stat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ByteWidth-1:0] rsp_byte,
   output logic                 rsp_byte_valid,
   output logic                 rsp_dc_level,
   output logic                 rsp_frame_end,
   output logic                 rsp_status,
   output logic                 rsp_last
);

   req_type               req_ff;
   logic                  bad_ff;
   logic                  bad_in;
   logic                  dc_ff;
   logic [IndexWidth-1:0] idx_ff;
   logic [IndexWidth-1:0] len;
   seq_byte_type          sb;

   logic                  valid_ff;
   logic [ByteWidth-1:0]  byte_ff;
   logic                  byte_valid_ff;
   logic                  dc_out_ff;
   logic                  fend_ff;
   logic                  status_ff;
   logic                  last_ff;

   logic [ByteWidth-1:0]  byte_in;
   logic                  byte_valid_in;
   logic                  dc_out_in;
   logic                  fend_in;
   logic                  status_in;

   assign bad_in        = check_bad(req);
   assign len           = seq_len(req_ff.mode, bad_ff);
   assign sb            = seq_byte(req_ff, idx_ff);
   assign stat.done     = (idx_ff == len);
   assign stat.out_free = !valid_ff || rsp_ready;

   always_comb begin
      if (bad_ff) begin
         byte_in       = CMD_FILL_ZERO;
         byte_valid_in = 1'b0;
         dc_out_in     = dc_ff;
         fend_in       = 1'b0;
         status_in     = 1'b1;
      end else if (req_ff.mode == MODE_WRITE) begin
         byte_in       = req_ff.value;
         byte_valid_in = 1'b1;
         dc_out_in     = dc_ff;
         fend_in       = req_ff.last_in;
         status_in     = 1'b0;
      end else begin
         byte_in       = sb.data;
         byte_valid_in = 1'b1;
         dc_out_in     = 1'b0;
         fend_in       = sb.fend;
         status_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_ff    <= 1'b0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            idx_ff <= '0;
            if (req.mode == MODE_DATALVL) begin
               dc_ff <= 1'b1;
            end else if (req.mode != MODE_WRITE && !bad_in) begin
               dc_ff <= 1'b0;
            end
         end else if (cmd.emit) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
         bad_ff <= bad_in;
      end
      if (cmd.emit) begin
         byte_ff       <= byte_in;
         byte_valid_ff <= byte_valid_in;
         dc_out_ff     <= dc_out_in;
         fend_ff       <= fend_in;
         status_ff     <= status_in;
         last_ff       <= (IndexWidth'(idx_ff + 1'b1) == len);
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_byte       = byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_dc_level   = dc_out_ff;
   assign rsp_frame_end  = fend_ff;
   assign rsp_status     = status_ff;
   assign rsp_last       = last_ff;

endmodule

>>> rtl/core/oled_command_sequencer.sv
// Turns display requests into the byte stream for a monochrome OLED controller.
// One request is taken at a time; its bytes leave one per cycle through the
// output register while rsp_tready stays high. Each request is loaded, its
// results are sent, and the sequencer returns to idle; the power-on init
// gives 25 results, a level change none, and a write or any single-byte
// command one. An invalid argument gives one result with status set and
// nothing to send.
module oled_command_sequencer
   import ocs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] value, [8] direction, [16:9] range_start, [24:17] range_end,
   // [32:25] speed, [40:33] row_offset, [47:41] zero
   input  logic [47:0] req_tdata,
   // [3:0] mode
   input  logic [3:0]  req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_byte, [8] frame_end, [15:9] zero
   output logic [15:0] rsp_tdata,
   // [0] byte_valid, [1] dc_level, [2] status
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   req_type      req;
   ocs_cmd_type  cmd;
   ocs_stat_type stat;

   logic [ByteWidth-1:0] rsp_byte;
   logic                 rsp_byte_valid;
   logic                 rsp_dc_level;
   logic                 rsp_frame_end;
   logic                 rsp_status;

   assign req.mode        = req_tuser;
   assign req.value       = req_tdata[7:0];
   assign req.direction   = req_tdata[8];
   assign req.range_start = req_tdata[16:9];
   assign req.range_end   = req_tdata[24:17];
   assign req.speed       = req_tdata[32:25];
   assign req.row_offset  = req_tdata[40:33];
   assign req.last_in     = req_tlast;

   ocs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ocs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req            (req),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_byte       (rsp_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_dc_level   (rsp_dc_level),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, rsp_frame_end, rsp_byte};
   assign rsp_tuser = {rsp_status, rsp_dc_level, rsp_byte_valid};

   a_status_alone : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tlast && !rsp_tuser[0] && !rsp_tdata[8])
      else $error("invalid-argument result is not a lone status item");

   a_busy_after_load : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in progress");

   a_data_is_sent : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tuser[0] && !rsp_tuser[2])
      else $error("frame end on a byte that is not sent");

endmodule
